>>> rtl/core/dede_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dede_pkg;

    localparam int DICT_ENTRIES = 256;
    localparam int CHAR_W       = 8;
    localparam int INDEX_W      = 8;
    localparam int LEN_W        = 4;
    localparam int KIND_W       = 2;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [CHAR_W-1:0] ESCAPE_RESET = 8'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_EOR  = 2'd2
    } dede_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;     // write dictionary char and length
        logic lookup;      // read length and first pattern char
        logic step;        // emit current pattern char, fetch next
        logic sel_newline; // single result is a newline, not the literal
        logic capture;     // hold the single result char
        logic emit_in;     // emit single result straight from the input
        logic emit_held;   // emit the held single result
    } dede_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic empty_entry;
        logic final_char;
        logic escape_match;
    } dede_status_t;

endpackage

`default_nettype wire

>>> rtl/core/dede_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dede_ctrl (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    input  wire  [1:0]                 kind,
    input  dede_pkg::dede_status_t     status,
    output dede_pkg::dede_cmd_t        cmd
);
    import dede_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_EXPAND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pend_reg;
    logic   pend_next;
    logic   accept;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (dede_kind_t'(kind))
                        KIND_LOAD:
                        begin
                            cmd.load_wr = 1'b1;
                        end
                        KIND_BYTE:
                        begin
                            if (pend_reg)
                            begin
                                pend_next   = 1'b0;
                                cmd.capture = 1'b1;
                                if (status.out_free)
                                    cmd.emit_in = 1'b1;
                                else
                                    state_next = ST_SINGLE;
                            end
                            else if (status.escape_match)
                            begin
                                pend_next = 1'b1;
                            end
                            else
                            begin
                                cmd.lookup = 1'b1;
                                state_next = ST_EXPAND;
                            end
                        end
                        KIND_EOR:
                        begin
                            pend_next       = 1'b0;
                            cmd.sel_newline = 1'b1;
                            cmd.capture     = 1'b1;
                            if (status.out_free)
                                cmd.emit_in = 1'b1;
                            else
                                state_next = ST_SINGLE;
                        end
                        default:
                        begin
                            // unused kind: drop
                        end
                    endcase
                end
            end
            ST_SINGLE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EXPAND:
            begin
                if (status.empty_entry)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.final_char)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.emit_in || cmd.emit_held) |-> status.out_free)
        else $error("result issued while output register is full");

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while expanding or holding a result");

    a_escape_sets_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_BYTE && !pend_reg && status.escape_match) |=> pend_reg)
        else $error("escape byte did not set pending escape");

endmodule

`default_nettype wire

>>> rtl/core/dede_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dede_dp #(
    parameter int MAX_PATTERN = 8
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_we,
    input  wire  [7:0]                 cfg_wdata,
    input  wire  [7:0]                 data_byte,
    input  wire  [7:0]                 entry_index,
    input  wire  [2:0]                 char_position,
    input  wire  [3:0]                 entry_length,
    input  dede_pkg::dede_cmd_t        cmd,
    output dede_pkg::dede_status_t     status,
    input  wire                        m_tready,
    output logic                       m_tvalid,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast
);
    import dede_pkg::*;

    localparam int POS_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int NW        = $clog2(MAX_PATTERN + 1);
    localparam int PAT_AW    = INDEX_W + POS_W;
    localparam int PAT_DEPTH = DICT_ENTRIES * (1 << POS_W);

    logic [CHAR_W-1:0]  pat_mem [PAT_DEPTH];
    logic [LEN_W-1:0]   len_mem [DICT_ENTRIES];

    logic [CHAR_W-1:0]  escape_reg;
    logic [CHAR_W-1:0]  pat_rdata_reg;
    logic [LEN_W-1:0]   len_rdata_reg;
    logic [INDEX_W-1:0] entry_reg;
    logic [NW-1:0]      pos_reg;
    logic [NW-1:0]      pos_inc;
    logic [CHAR_W-1:0]  held_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;

    logic [7:0]         cpos_ext;
    logic [7:0]         len_ext;
    logic [7:0]         n_sat;
    logic [NW-1:0]      n_chars;
    logic               wr_pos_ok;
    logic [PAT_AW-1:0]  wr_addr;
    logic [PAT_AW-1:0]  rd_addr;
    logic               rd_en;
    logic [CHAR_W-1:0]  single_char;
    logic               load_out;

    assign cpos_ext  = {5'd0, char_position};
    assign wr_pos_ok = cpos_ext < 8'(MAX_PATTERN);
    assign wr_addr   = {entry_index, cpos_ext[POS_W-1:0]};

    assign pos_inc = pos_reg + 1'b1;
    assign rd_en   = cmd.lookup || cmd.step;
    assign rd_addr = cmd.lookup ? {data_byte, {POS_W{1'b0}}}
                                : {entry_reg, pos_inc[POS_W-1:0]};

    // clamp stored length to the pattern size
    assign len_ext = {4'd0, len_rdata_reg};
    assign n_sat   = (len_ext > 8'(MAX_PATTERN)) ? 8'(MAX_PATTERN) : len_ext;
    assign n_chars = n_sat[NW-1:0];

    assign single_char = cmd.sel_newline ? NEWLINE_CHAR : data_byte;
    assign load_out    = cmd.step || cmd.emit_in || cmd.emit_held;

    assign status.out_free     = !out_valid_reg || m_tready;
    assign status.empty_entry  = (n_chars == '0);
    assign status.final_char   = (pos_inc == n_chars);
    assign status.escape_match = (data_byte == escape_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && wr_pos_ok)
            pat_mem[wr_addr] <= data_byte;
        if (rd_en)
            pat_rdata_reg <= pat_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            len_mem[entry_index] <= entry_length;
        if (cmd.lookup)
            len_rdata_reg <= len_mem[data_byte];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg    <= ESCAPE_RESET;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                escape_reg <= cfg_wdata;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cmd.lookup)
                pos_reg <= '0;
            else if (cmd.step)
                pos_reg <= pos_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
            entry_reg <= data_byte;
        if (cmd.capture)
            held_reg <= single_char;
        if (cmd.step)
        begin
            out_char_reg <= pat_rdata_reg;
            out_last_reg <= status.final_char;
        end
        else if (cmd.emit_in)
        begin
            out_char_reg <= single_char;
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit_held)
        begin
            out_char_reg <= held_reg;
            out_last_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dictionary_escape_decompressor_top.sv
// Channel   Dir  Handshake            Payload
// cfg       in   cfg_we               cfg_wdata: escape code
// s         in   s_tvalid / s_tready  s_tdata: byte, entry, position, length; s_tuser: kind
// m         out  m_tvalid / m_tready  m_tdata: char; m_tlast: final char of the request
//
// Load, escape, literal and end-of-record requests are each handled on acceptance.
// A dictionary byte first looks up the entry length, then steps through its
// pattern chars in order, paced by the single read port of the pattern memory
// and held while m is stalled; an empty entry emits nothing but still enters expand.
// Reset clears control state and sets escape code 32; dictionary undefined until loaded.
// A stalled m channel holds its result; a literal or newline waiting on it is
// held internally while the next request is refused.
`timescale 1ns / 1ps
`default_nettype none

module dictionary_escape_decompressor_top #(
    parameter int MAX_PATTERN = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata,      // escape_code
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,        // data_byte[7:0], entry_index[15:8],
                                        // char_position[18:16], entry_length[22:19]
    input  wire  [1:0]  s_tuser,        // kind[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,        // out_char[7:0]
    output logic        m_tlast
);
    import dede_pkg::*;

    dede_cmd_t    cmd;
    dede_status_t status;

    dede_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    dede_dp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .data_byte     (s_tdata[7:0]),
        .entry_index   (s_tdata[15:8]),
        .char_position (s_tdata[18:16]),
        .entry_length  (s_tdata[22:19]),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

`default_nettype wire
